### hdl/cjmi_pkg.sv
package cjmi_pkg;

	localparam int ENT_W    = 64;                // packed complex word
	localparam int PART_W   = 32;                // one real or imaginary part
	localparam int PROD_W   = 2 * PART_W;        // part x part
	localparam int NUM_W    = PROD_W + 2;        // four-term sum of products
	localparam int HALF_W   = NUM_W - PART_W;    // upper slice for the wide multiply
	localparam int WPROD_W  = 2 * NUM_W - 2;     // wide product
	localparam int SUM_W    = WPROD_W + 1;       // two wide products added
	localparam int DEN_W    = WPROD_W;           // |det|^2, never negative
	localparam int QBITS    = PART_W - 1;        // quotient bits below saturation
	localparam int MAG_W    = DEN_W + QBITS + 1; // shifted dividend and divisor
	localparam int NENT     = 4;
	localparam int NLANE    = 2 * NENT;

	localparam logic [PART_W-1:0] SAT_POS = {1'b0, {(PART_W-1){1'b1}}};
	localparam logic [PART_W-1:0] SAT_NEG = {1'b1, {(PART_W-1){1'b0}}};

	typedef logic [ENT_W-1:0]          ent_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic signed [WPROD_W-1:0] wprod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [DEN_W-1:0]          den_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [PART_W-1:0]         part_t;

	typedef struct packed {
		num_t re;
		num_t im;
	} cnum_t;

endpackage

### hdl/conj_matrix_times_inverse_transpose_2x2.sv
// R = conj(A) * inverse(transpose(H)) for complex 2x2 matrices, Q(FRAC_BITS) parts.
// Pipeline stages: 2 part products/sums, 2 wide multiply, 1 numerator sum,
// 34 in the divider (magnitude, saturation test, 31 quotient bits, sign).
// Throughput one word per cycle unless a stalled output word freezes the pipeline.
// arst_n clears only the valid bits; data registers are not reset.
module conj_matrix_times_inverse_transpose_2x2 #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [63:0]           a_00,
	input  logic [63:0]           a_01,
	input  logic [63:0]           a_10,
	input  logic [63:0]           a_11,
	input  logic [63:0]           h_00,
	input  logic [63:0]           h_01,
	input  logic [63:0]           h_10,
	input  logic [63:0]           h_11,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           r_00,
	output logic [63:0]           r_01,
	output logic [63:0]           r_10,
	output logic [63:0]           r_11,
	output logic                  singular
);
	import cjmi_pkg::*;

	localparam int LAT = 39;

	logic             en;
	logic [LAT-1:0]   vld_q;
	logic [LAT-3:0]   sing_q;
	logic             det_zero;

	ent_t    a_arr [NENT];
	ent_t    h_arr [NENT];
	cnum_t   det;
	cnum_t   n [NENT];
	wprod_t  sq_re, sq_im;
	wprod_t  pa [NENT], pb [NENT], pc [NENT], pd [NENT];
	den_t    den_s5;
	sum_t    num_s5 [NLANE];
	part_t   q [NLANE];

	// whole pipeline advances together; only a stalled word at the output holds it
	assign en        = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = vld_q[LAT-1] && out_stall;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign a_arr[0] = a_00;
	assign a_arr[1] = a_01;
	assign a_arr[2] = a_10;
	assign a_arr[3] = a_11;
	assign h_arr[0] = h_00;
	assign h_arr[1] = h_01;
	assign h_arr[2] = h_10;
	assign h_arr[3] = h_11;

	// stages 1-2: det and the four adjugate numerators, exact
	cjmi_front u_front (
		.clk (clk),
		.en  (en),
		.a   (a_arr),
		.h   (h_arr),
		.det (det),
		.n   (n)
	);

	// singular flag rides alongside from stage 3
	assign det_zero = (det.re == '0) && (det.im == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= {sing_q[LAT-4:0], det_zero};
		end
	end

	// stages 3-4: |det|^2 and N * conj(det)
	cjmi_wmul u_sq_re (.clk(clk), .en(en), .x(det.re), .y(det.re), .p(sq_re));
	cjmi_wmul u_sq_im (.clk(clk), .en(en), .x(det.im), .y(det.im), .p(sq_im));

	for (genvar e = 0; e < NENT; e++) begin : g_ent
		cjmi_wmul u_pa (.clk(clk), .en(en), .x(n[e].re), .y(det.re), .p(pa[e]));
		cjmi_wmul u_pb (.clk(clk), .en(en), .x(n[e].im), .y(det.im), .p(pb[e]));
		cjmi_wmul u_pc (.clk(clk), .en(en), .x(n[e].im), .y(det.re), .p(pc[e]));
		cjmi_wmul u_pd (.clk(clk), .en(en), .x(n[e].re), .y(det.im), .p(pd[e]));

		// stage 5: lane 2e real, lane 2e+1 imaginary
		always_ff @(posedge clk) begin
			if (en) begin
				num_s5[2*e]   <= SUM_W'(pa[e]) + SUM_W'(pb[e]);
				num_s5[2*e+1] <= SUM_W'(pc[e]) - SUM_W'(pd[e]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= den_t'(sq_re) + den_t'(sq_im);
		end
	end

	// stages 6-39: truncating, saturating quotient per lane
	cjmi_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk (clk),
		.en  (en),
		.num (num_s5),
		.den (den_s5),
		.q   (q)
	);

	// a singular H forces zero entries over the divider's saturated words
	assign singular = sing_q[LAT-3];
	assign r_00 = singular ? '0 : {q[0], q[1]};
	assign r_01 = singular ? '0 : {q[2], q[3]};
	assign r_10 = singular ? '0 : {q[4], q[5]};
	assign r_11 = singular ? '0 : {q[6], q[7]};

	a_sing_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (r_00 == '0) && (r_01 == '0) && (r_10 == '0) && (r_11 == '0))
		else $error("singular word with nonzero entries");

	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(r_01) && $stable(singular))
		else $error("stalled result word changed");

	a_enter : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted word not tracked in pipeline");

	a_frozen : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q) && $stable(sing_q))
		else $error("pipeline moved while stalled");

endmodule

### hdl/cjmi_front.sv
module cjmi_front (
	input  logic             clk,
	input  logic             en,
	input  cjmi_pkg::ent_t   a [cjmi_pkg::NENT],
	input  cjmi_pkg::ent_t   h [cjmi_pkg::NENT],
	output cjmi_pkg::cnum_t  det,
	output cjmi_pkg::cnum_t  n [cjmi_pkg::NENT]
);
	import cjmi_pkg::*;

	// entry index: 0 = (0,0), 1 = (0,1), 2 = (1,0), 3 = (1,1)
	// numerator e = conj(A[AP]) * H[HQ] - conj(A[AR]) * H[HS]
	localparam int AP [NENT] = '{0, 1, 2, 3};
	localparam int HQ [NENT] = '{3, 0, 3, 0};
	localparam int AR [NENT] = '{1, 0, 3, 2};
	localparam int HS [NENT] = '{1, 2, 1, 2};

	logic signed [PART_W-1:0] ar [NENT];
	logic signed [PART_W-1:0] ai [NENT];
	logic signed [PART_W-1:0] hr [NENT];
	logic signed [PART_W-1:0] hi [NENT];

	logic signed [PROD_W-1:0] dp_s1 [8];
	logic signed [PROD_W-1:0] np_s1 [NENT][8];
	cnum_t det_s2;
	cnum_t n_s2 [NENT];

	for (genvar i = 0; i < NENT; i++) begin : g_split
		assign ar[i] = a[i][ENT_W-1:PART_W];
		assign ai[i] = a[i][PART_W-1:0];
		assign hr[i] = h[i][ENT_W-1:PART_W];
		assign hi[i] = h[i][PART_W-1:0];
	end

	// det = H00*H11 - H01*H10
	always_ff @(posedge clk) begin
		if (en) begin
			dp_s1[0] <= hr[0] * hr[3];
			dp_s1[1] <= hi[0] * hi[3];
			dp_s1[2] <= hr[1] * hr[2];
			dp_s1[3] <= hi[1] * hi[2];
			dp_s1[4] <= hr[0] * hi[3];
			dp_s1[5] <= hi[0] * hr[3];
			dp_s1[6] <= hr[1] * hi[2];
			dp_s1[7] <= hi[1] * hr[2];
			det_s2.re <= NUM_W'(dp_s1[0]) - NUM_W'(dp_s1[1]) - NUM_W'(dp_s1[2])
				+ NUM_W'(dp_s1[3]);
			det_s2.im <= NUM_W'(dp_s1[4]) + NUM_W'(dp_s1[5]) - NUM_W'(dp_s1[6])
				- NUM_W'(dp_s1[7]);
		end
	end

	// conj(a)*h: re = ar*hr + ai*hi, im = ar*hi - ai*hr
	for (genvar e = 0; e < NENT; e++) begin : g_num
		always_ff @(posedge clk) begin
			if (en) begin
				np_s1[e][0] <= ar[AP[e]] * hr[HQ[e]];
				np_s1[e][1] <= ai[AP[e]] * hi[HQ[e]];
				np_s1[e][2] <= ar[AR[e]] * hr[HS[e]];
				np_s1[e][3] <= ai[AR[e]] * hi[HS[e]];
				np_s1[e][4] <= ar[AP[e]] * hi[HQ[e]];
				np_s1[e][5] <= ai[AP[e]] * hr[HQ[e]];
				np_s1[e][6] <= ar[AR[e]] * hi[HS[e]];
				np_s1[e][7] <= ai[AR[e]] * hr[HS[e]];
				n_s2[e].re <= NUM_W'(np_s1[e][0]) + NUM_W'(np_s1[e][1])
					- NUM_W'(np_s1[e][2]) - NUM_W'(np_s1[e][3]);
				n_s2[e].im <= NUM_W'(np_s1[e][4]) - NUM_W'(np_s1[e][5])
					- NUM_W'(np_s1[e][6]) + NUM_W'(np_s1[e][7]);
			end
		end
		assign n[e] = n_s2[e];
	end

	assign det = det_s2;

endmodule

### hdl/cjmi_wmul.sv
module cjmi_wmul (
	input  logic            clk,
	input  logic            en,
	input  cjmi_pkg::num_t  x,
	input  cjmi_pkg::num_t  y,
	output cjmi_pkg::wprod_t p
);
	import cjmi_pkg::*;

	// x = xh*2^32 + xl, xh signed, xl unsigned; four partial products
	logic signed [HALF_W-1:0]     xh, yh;
	logic [PART_W-1:0]            xl, yl;
	logic signed [2*HALF_W-1:0]   hh_s1;
	logic signed [HALF_W+PART_W:0] hl_s1, lh_s1;
	logic [PROD_W-1:0]            ll_s1;
	wprod_t                       p_s2;

	assign xh = x[NUM_W-1:PART_W];
	assign yh = y[NUM_W-1:PART_W];
	assign xl = x[PART_W-1:0];
	assign yl = y[PART_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= xh * yh;
			hl_s1 <= xh * $signed({1'b0, yl});
			lh_s1 <= $signed({1'b0, xl}) * yh;
			ll_s1 <= xl * yl;
			p_s2  <= (WPROD_W'(hh_s1) << (2 * PART_W)) + (WPROD_W'(hl_s1) << PART_W)
				+ (WPROD_W'(lh_s1) << PART_W) + WPROD_W'(ll_s1);
		end
	end

	assign p = p_s2;

endmodule

### hdl/cjmi_div.sv
module cjmi_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            en,
	input  cjmi_pkg::sum_t  num [cjmi_pkg::NLANE],
	input  cjmi_pkg::den_t  den,
	output cjmi_pkg::part_t q   [cjmi_pkg::NLANE]
);
	import cjmi_pkg::*;

	// stage 0: magnitude, stage 1: saturation test, then one quotient bit per stage
	localparam int NST = QBITS + 2;

	mag_t             mag_s [NST][NLANE];
	logic             neg_s [NST][NLANE];
	logic             sat_s [NST][NLANE];
	logic [QBITS-1:0] qb_s  [NST][NLANE];
	den_t             den_s [NST];
	part_t            q_s   [NLANE];
	sum_t             absv  [NLANE];

	for (genvar l = 0; l < NLANE; l++) begin : g_abs
		assign absv[l] = num[l][SUM_W-1] ? SUM_W'(-num[l]) : num[l];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			den_s[1] <= den_s[0];
			for (int l = 0; l < NLANE; l++) begin
				neg_s[0][l] <= num[l][SUM_W-1];
				sat_s[0][l] <= 1'b0;
				qb_s[0][l]  <= '0;
				mag_s[0][l] <= mag_t'($unsigned(absv[l])) << FRAC_BITS;
				neg_s[1][l] <= neg_s[0][l];
				sat_s[1][l] <= mag_s[0][l] >= (mag_t'(den_s[0]) << QBITS);
				qb_s[1][l]  <= '0;
				mag_s[1][l] <= mag_s[0][l];
			end
		end
	end

	for (genvar t = 2; t < NST; t++) begin : g_bit
		localparam int K = NST - 1 - t;
		mag_t dsh;
		assign dsh = mag_t'(den_s[t-1]) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[t] <= den_s[t-1];
				for (int l = 0; l < NLANE; l++) begin
					neg_s[t][l] <= neg_s[t-1][l];
					sat_s[t][l] <= sat_s[t-1][l];
					if (mag_s[t-1][l] >= dsh) begin
						mag_s[t][l] <= mag_s[t-1][l] - dsh;
						qb_s[t][l]  <= qb_s[t-1][l] | (QBITS'(1) << K);
					end else begin
						mag_s[t][l] <= mag_s[t-1][l];
						qb_s[t][l]  <= qb_s[t-1][l];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NLANE; l++) begin
				if (sat_s[NST-1][l])
					q_s[l] <= neg_s[NST-1][l] ? SAT_NEG : SAT_POS;
				else if (neg_s[NST-1][l])
					q_s[l] <= PART_W'(0) - {1'b0, qb_s[NST-1][l]};
				else
					q_s[l] <= {1'b0, qb_s[NST-1][l]};
			end
		end
	end

	assign q = q_s;

endmodule

### tb/sv/conj_matrix_times_inverse_transpose_2x2_test.sv
`timescale 1ns / 1ps

// Stream checker for conj(A) * inverse(transpose(H)) on 2x2 complex matrices.
// A queue of words is filled up front: a directed set of corner cases, then
// random matrix pairs. The driver feeds them on the falling edge, and a
// predictor works out each accepted word's result. The monitor compares
// every result with the oldest prediction, field by field.
module conj_matrix_times_inverse_transpose_2x2_test;
	import cjmi_pkg::*;

	localparam int FB       = 16;
	localparam int N_RANDOM = 380;
	localparam int MAX_SHOW = 10;

	// one input word: entries 0..3 are A (00,01,10,11), 4..7 are H
	typedef logic [7:0][63:0] word_t;
	typedef struct {
		logic [63:0] r00, r01, r10, r11;
		logic        sing;
	} result_t;
	// wide enough for any exact product, sum or shifted dividend
	typedef logic signed [255:0] wide_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] a_00, a_01, a_10, a_11;
	logic [63:0] h_00, h_01, h_10, h_11;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] r_00, r_01, r_10, r_11;
	logic        singular;

	word_t   word_q[$];     // words not yet driven
	result_t result_q[$];   // predictions waiting for the block
	bit      in_taken;      // set at the rising edge a word is accepted
	int      words_in;
	int      words_out;
	int      n_singular;
	int      n_saturated;
	int      mismatches;

	conj_matrix_times_inverse_transpose_2x2 #(.FRAC_BITS(FB)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a_00      (a_00),
		.a_01      (a_01),
		.a_10      (a_10),
		.a_11      (a_11),
		.h_00      (h_00),
		.h_01      (h_01),
		.h_10      (h_10),
		.h_11      (h_11),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.r_00      (r_00),
		.r_01      (r_01),
		.r_10      (r_10),
		.r_11      (r_11),
		.singular  (singular)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic wide_t re_of(logic [63:0] e);
		wide_t w;
		w = $signed(e[63:32]);
		return w;
	endfunction

	function automatic wide_t im_of(logic [63:0] e);
		wide_t w;
		w = $signed(e[31:0]);
		return w;
	endfunction

	// exact complex product
	function automatic void cmul(input wide_t ar, ai, br, bi, output wide_t rr, ri);
		rr = ar * br - ai * bi;
		ri = ar * bi + ai * br;
	endfunction

	// trunc(num * 2^FB / den) with saturation; den is positive
	function automatic part_t quotient(wide_t num, wide_t den);
		logic        neg;
		logic [255:0] mag;
		logic [255:0] q;
		neg = num < 0;
		mag = neg ? -num : num;
		q   = (mag << FB) / den;
		if (q >= (256'd1 << 31))
			return neg ? SAT_NEG : SAT_POS;
		return neg ? part_t'(-q[31:0]) : q[31:0];
	endfunction

	// numerator conj(a)*hp - conj(b)*hq, then divided by det
	function automatic logic [63:0] entry(logic [63:0] a, logic [63:0] hp, logic [63:0] b,
			logic [63:0] hq, wide_t dr, wide_t di, wide_t den);
		wide_t pr, pi, qr, qi, nr, ni;
		cmul(re_of(a), -im_of(a), re_of(hp), im_of(hp), pr, pi);
		cmul(re_of(b), -im_of(b), re_of(hq), im_of(hq), qr, qi);
		nr = pr - qr;
		ni = pi - qi;
		return {quotient(nr * dr + ni * di, den), quotient(ni * dr - nr * di, den)};
	endfunction

	function automatic result_t predict_inverse(word_t w);
		result_t res;
		wide_t   pr, pi, qr, qi, dr, di, den;
		cmul(re_of(w[4]), im_of(w[4]), re_of(w[7]), im_of(w[7]), pr, pi);
		cmul(re_of(w[5]), im_of(w[5]), re_of(w[6]), im_of(w[6]), qr, qi);
		dr = pr - qr;
		di = pi - qi;
		if (dr == 0 && di == 0) begin
			res = '{64'd0, 64'd0, 64'd0, 64'd0, 1'b1};
			return res;
		end
		den      = dr * dr + di * di;
		res.r00  = entry(w[0], w[7], w[1], w[5], dr, di, den);
		res.r01  = entry(w[1], w[4], w[0], w[6], dr, di, den);
		res.r10  = entry(w[2], w[7], w[3], w[5], dr, di, den);
		res.r11  = entry(w[3], w[4], w[2], w[6], dr, di, den);
		res.sing = 1'b0;
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			4: return $urandom_range(0, 1) ? 32'(1 << FB) : 32'(-(1 << FB));
			default: return 32'($signed($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	function automatic logic [63:0] rand_entry();
		return {rand_part(), rand_part()};
	endfunction

	function automatic word_t rand_word();
		word_t w;
		for (int i = 0; i < 8; i++)
			w[i] = rand_entry();
		// a few rank-one H (singular, non-zero entries) and a few diagonal H
		case ($urandom_range(0, 9))
			0: begin
				w[5] = w[4];
				w[6] = w[7];
				w[7] = w[4];
				w[6] = w[4];
			end
			1: begin
				w[5] = 64'd0;
				w[6] = 64'd0;
			end
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		logic [63:0] one, neg_one, top, bot;
		word_t       w;
		one     = {32'(1 << FB), 32'd0};
		neg_one = {32'(-(1 << FB)), 32'd0};
		top     = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
		bot     = {32'h8000_0000, 32'h8000_0000};

		// zero H: singular with every entry zero
		word_q.push_back({64'd0, 64'd0, 64'd0, 64'd0, top, bot, one, neg_one});
		// identity H: result is conj(A)
		word_q.push_back({one, 64'd0, 64'd0, one, 64'hDEAD_BEEF_1234_5678, bot, top, neg_one});
		// all-equal H: non-zero yet singular
		word_q.push_back({top, top, top, top, one, one, one, one});
		// anti-diagonal H: det is negative
		word_q.push_back({64'd0, one, one, 64'd0, one, top, bot, neg_one});
		// tiny det with huge A: saturation both ways
		word_q.push_back({64'd1, 64'd0, 64'd0, 64'd1, top, bot, top, bot});
		word_q.push_back({64'd1, 64'd0, 64'd0, 64'd1, bot, top, bot, top});
		// purely imaginary H
		word_q.push_back({{32'd0, 32'(1 << FB)}, 64'd0, 64'd0, {32'd0, 32'(1 << FB)},
			one, {32'd0, 32'(3 << FB)}, neg_one, 64'd5});
		// extreme words, H or A parts at the limits
		word_q.push_back({bot, top, top, bot, top, bot, bot, top});
		word_q.push_back({top, top, top, top, bot, bot, bot, bot});
		word_q.push_back({64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd1, top, top, bot, bot});
		// truncation towards zero: thirds
		word_q.push_back({{32'(3 << FB), 32'd0}, 64'd0, 64'd0, {32'(3 << FB), 32'd0},
			one, {32'(-(1 << FB)), 32'd7}, 64'd3, neg_one});
		for (int i = 0; i < 8; i++) begin
			w = {8{64'd0}};
			w[i] = 64'hFFFF_FFFF_FFFF_FFFF;
			w[(i + 3) % 8] = 64'h5555_5555_AAAA_AAAA;
			word_q.push_back({w[7:4] | {one, 64'd0, 64'd0, one}, w[3:0]});
		end
		for (int i = 0; i < N_RANDOM; i++)
			word_q.push_back(rand_word());
	end

	// ---------------------------------------------------------------- driver

	// quiet window: neither side idles, so the pipeline runs flat out
	function automatic bit quiet();
		return words_in >= 150 && words_in < 260;
	endfunction

	always @(negedge clk) begin
		word_t w;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (word_q.size() > 0 && (quiet() || $urandom_range(0, 99) >= 17)) begin
					w = word_q.pop_front();
					{h_11, h_10, h_01, h_00, a_11, a_10, a_01, a_00} <= w;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= quiet() ? 1'b0 : ($urandom_range(0, 99) < 17);
			in_taken = 1'b0;
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic bit bad(logic [63:0] got, logic [63:0] want);
		return got !== want;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && in_valid && !in_stall) begin
			want = predict_inverse({h_11, h_10, h_01, h_00, a_11, a_10, a_01, a_00});
			result_q.push_back(want);
			in_taken = 1'b1;
			words_in++;
			if (want.sing)
				n_singular++;
			if (want.r00[63:32] == SAT_POS || want.r00[63:32] == SAT_NEG
					|| want.r00[31:0] == SAT_POS || want.r00[31:0] == SAT_NEG)
				n_saturated++;
		end
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOW)
					$display("%0t: result word with nothing expected", $realtime);
			end else begin
				want = result_q.pop_front();
				if (bad(r_00, want.r00) || bad(r_01, want.r01) || bad(r_10, want.r10)
						|| bad(r_11, want.r11) || singular !== want.sing) begin
					mismatches++;
					if (mismatches <= MAX_SHOW) begin
						$display("%0t: word %0d mismatch", $realtime, words_out - 1);
						$display("  r_00 exp %h got %h  r_01 exp %h got %h",
							want.r00, r_00, want.r01, r_01);
						$display("  r_10 exp %h got %h  r_11 exp %h got %h",
							want.r10, r_10, want.r11, r_11);
						$display("  singular exp %b got %b", want.sing, singular);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- run control

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_stall = 1'b0;
		in_taken  = 1'b0;
		{a_00, a_01, a_10, a_11, h_00, h_01, h_10, h_11} = '0;
		words_in    = 0;
		words_out   = 0;
		n_singular  = 0;
		n_saturated = 0;
		mismatches  = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// all words handed over, then drain the pipeline
		while (word_q.size() > 0 || in_valid)
			@(posedge clk);
		while (result_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (result_q.size() > 0)
			mismatches++;
		$display("%0d matrix pairs checked, %0d with singular H, %0d with a saturated r_00 part",
			words_out, n_singular, n_saturated);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("conj_matrix_times_inverse_transpose_2x2 verification clean");
		else
			$display("conj_matrix_times_inverse_transpose_2x2 verification failed");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#400000;
		$display("timeout with %0d results outstanding", result_q.size());
		$display("conj_matrix_times_inverse_transpose_2x2 verification failed");
		$finish;
	end

endmodule
